@@ design/dual_stepper_door_sequencer_defines.svh @@
// Assertion macros for the door sequencer.
`ifndef DUAL_STEPPER_DOOR_SEQUENCER_DEFINES_SVH
`define DUAL_STEPPER_DOOR_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define DSS_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("dss assertion failed");
`define DSS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("dss assertion failed");
`else
`define DSS_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons)
`define DSS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif

`endif

@@ design/dss_pkg.sv @@
package dss_pkg;

    localparam int COUNT_BITS_DEF = 10;
    localparam int LIMIT_W        = 10;
    localparam logic [LIMIT_W-1:0] STEPS_RESET = 10'd48;

    typedef enum logic [1:0] {
        MODE_OPEN    = 2'd0,
        MODE_CLOSING = 2'd1,
        MODE_CLOSED  = 2'd2,
        MODE_OPENING = 2'd3
    } mode_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } opcode_t;

    typedef enum logic {
        ACT_OPEN  = 1'b0,
        ACT_CLOSE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        REG_STEPS_TO_OPEN  = 2'd0,
        REG_STEPS_TO_CLOSE = 2'd1
    } reg_index_t;

    // full-step pattern: bit0 coil A, bit1 coil B
    function automatic logic [1:0] gray_pattern(input logic [1:0] phase);
        logic [1:0] pat;
        unique case (phase)
            2'd0: pat = 2'b11;
            2'd1: pat = 2'b01;
            2'd2: pat = 2'b00;
            2'd3: pat = 2'b10;
            default: pat = 2'b00;
        endcase
        return pat;
    endfunction

endpackage

@@ design/dual_stepper_door_sequencer.sv @@
// An accepted word goes to the input register, then to the state registers.
// Throughput: one word per cycle; the input register hands to the state/result
// registers whenever the result stage is empty or being taken.
// Reset: doors open, phases and step counters zero, coils off, limits 48.
`include "dual_stepper_door_sequencer_defines.svh"

module dual_stepper_door_sequencer
    import dss_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic               door_select,
    input  logic               action,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         coil_pins,
    output logic [1:0]         front_mode,
    output logic [1:0]         back_mode,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    logic                  s1_vld_reg;
    opcode_t               s1_op_reg;
    logic                  s1_door_reg;
    action_t               s1_act_reg;
    logic                  out_vld_reg;
    logic                  adv;

    logic [LIMIT_W-1:0]    open_lim_reg;
    logic [LIMIT_W-1:0]    close_lim_reg;

    mode_t                 mode_reg [2];
    mode_t                 mode_next [2];
    logic [1:0]            phase_reg [2];
    logic [1:0]            phase_next [2];
    logic [COUNT_BITS-1:0] open_cnt_reg [2];
    logic [COUNT_BITS-1:0] open_cnt_next [2];
    logic [COUNT_BITS-1:0] close_cnt_reg [2];
    logic [COUNT_BITS-1:0] close_cnt_next [2];
    logic [3:0]            coil_reg;
    logic [3:0]            coil_next;

    assign adv       = s1_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !s1_vld_reg || adv;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_vld_reg;
    assign coil_pins  = coil_reg;
    assign front_mode = mode_reg[0];
    assign back_mode  = mode_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_vld_reg <= in_valid;
            if (adv)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= opcode_t'(opcode);
            s1_door_reg <= door_select;
            s1_act_reg  <= action_t'(action);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_lim_reg  <= STEPS_RESET;
            close_lim_reg <= STEPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                REG_STEPS_TO_OPEN:  open_lim_reg  <= cfg_data;
                REG_STEPS_TO_CLOSE: close_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        coil_next = coil_reg;
        for (int d = 0; d < 2; d++)
        begin
            mode_next[d]      = mode_reg[d];
            phase_next[d]     = phase_reg[d];
            open_cnt_next[d]  = open_cnt_reg[d];
            close_cnt_next[d] = close_cnt_reg[d];
            if (s1_op_reg == OP_CMD)
            begin
                if (s1_door_reg == 1'(d))
                    mode_next[d] = (s1_act_reg == ACT_CLOSE) ? MODE_CLOSING : MODE_OPENING;
            end
            else
            begin
                unique case (mode_reg[d])
                    MODE_OPENING:
                    begin
                        if (CMP_W'(open_cnt_reg[d]) == CMP_W'(open_lim_reg))
                        begin
                            mode_next[d]     = MODE_OPEN;
                            open_cnt_next[d] = '0;
                        end
                        else
                        begin
                            phase_next[d]    = phase_reg[d] - 2'd1;
                            open_cnt_next[d] = open_cnt_reg[d] + 1'b1;
                            {coil_next[d+2], coil_next[d]} = gray_pattern(phase_next[d]);
                        end
                    end
                    MODE_CLOSING:
                    begin
                        if (CMP_W'(close_cnt_reg[d]) == CMP_W'(close_lim_reg))
                        begin
                            mode_next[d]      = MODE_CLOSED;
                            close_cnt_next[d] = '0;
                        end
                        else
                        begin
                            phase_next[d]     = phase_reg[d] + 2'd1;
                            close_cnt_next[d] = close_cnt_reg[d] + 1'b1;
                            {coil_next[d+2], coil_next[d]} = gray_pattern(phase_next[d]);
                        end
                    end
                    MODE_OPEN, MODE_CLOSED: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg <= '0;
            for (int d = 0; d < 2; d++)
            begin
                mode_reg[d]      <= MODE_OPEN;
                phase_reg[d]     <= '0;
                open_cnt_reg[d]  <= '0;
                close_cnt_reg[d] <= '0;
            end
        end
        else if (adv)
        begin
            coil_reg <= coil_next;
            for (int d = 0; d < 2; d++)
            begin
                mode_reg[d]      <= mode_next[d];
                phase_reg[d]     <= phase_next[d];
                open_cnt_reg[d]  <= open_cnt_next[d];
                close_cnt_reg[d] <= close_cnt_next[d];
            end
        end
    end

    `DSS_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_ready,
        s1_vld_reg && out_vld_reg && !out_ready)
    `DSS_ASSERT_NEXT(a_cmd_keeps_coils, clk, rst_n, adv && (s1_op_reg == OP_CMD),
        $stable(coil_reg))
    `DSS_ASSERT_NEXT(a_rest_front_keeps_pins, clk, rst_n,
        adv && (s1_op_reg == OP_TICK) &&
        (mode_reg[0] == MODE_OPEN || mode_reg[0] == MODE_CLOSED),
        coil_reg[0] == $past(coil_reg[0]) && coil_reg[2] == $past(coil_reg[2]))

endmodule
